FILE: src/psub_pkg.sv
// Package: constants, widths, types and tables of the powerline interference subtractor.
`default_nettype none

package psub_pkg;

    localparam int CYCLE_LEN    = 5;
    localparam int RING_LEN     = 8;
    localparam int OUTPUT_DELAY = 3;

    localparam int THRESH_RESET = 150;

    // fixed taps into the sample line, offsets wrap modulo the ring length
    localparam int TAP_CYCLE  = CYCLE_LEN % RING_LEN;
    localparam int TAP_CYCLE1 = (CYCLE_LEN + 1) % RING_LEN;
    localparam int TAP_DELAY  = OUTPUT_DELAY % RING_LEN;

    // run counter holds 1..CYCLE_LEN
    localparam int COUNT_W = $clog2(CYCLE_LEN + 1);

    // summing rotates the sample line a whole number of turns
    localparam int SUM_LEN = ((CYCLE_LEN + RING_LEN - 1) / RING_LEN) * RING_LEN;
    localparam int STEP_W  = $clog2(SUM_LEN + 1);

    // period sum minus half difference, |s| <= (CYCLE_LEN+1)*32768
    localparam int SUM_W  = $clog2((CYCLE_LEN + 1) * 32768) + 1;
    // biased dividend, always non-negative
    localparam int U_W    = SUM_W - 1 + $clog2(CYCLE_LEN + 1);
    localparam int DREM_W = $clog2(CYCLE_LEN);
    localparam logic [U_W-1:0] DIV_BIAS = U_W'(CYCLE_LEN) << (SUM_W - 1);

    // reciprocal of CYCLE_LEN, rounded up; exact floor for any U_W-bit dividend
    localparam int DIV_SHIFT = U_W + DREM_W;
    localparam int PROD_W    = 2 * U_W + 1;
    localparam logic [PROD_W-1:0] DIV_RECIP =
        PROD_W'(((64'd1 << DIV_SHIFT) + 64'(CYCLE_LEN) - 64'd1) / 64'(CYCLE_LEN));

    // Q20.16 interference before saturation
    localparam int Q_W = SUM_W + 17;

    localparam logic REG_THRESHOLD = 1'b0;

    typedef logic signed [15:0] t_sample;
    typedef logic signed [31:0] t_intf;

    typedef struct packed {
        logic shift;   // new sample enters at cell 0
        logic rotate;  // line turns one place toward cell 0
    } t_ring_ctl;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SUB,
        ST_SUM,
        ST_PREP,
        ST_DIV,
        ST_FIN
    } t_state;

    // fraction floor((2*65536*rm + N) / 2N), rm = remainder 0..N-1
    typedef logic [15:0] t_frac_tab [CYCLE_LEN];

    function automatic t_frac_tab frac_table();
        t_frac_tab tab;
        for (int i = 0; i < CYCLE_LEN; i++) begin
            tab[i] = 16'((2 * 65536 * i + CYCLE_LEN) / (2 * CYCLE_LEN));
        end
        return tab;
    endfunction

    localparam t_frac_tab FRAC_TAB = frac_table();

endpackage

`default_nettype wire

FILE: src/psub_ring_cell.sv
// One cell of the sample line: shifts in from its left, rotates in from its right.
`default_nettype none

module psub_ring_cell (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  psub_pkg::t_ring_ctl  i_ctl,
    input  psub_pkg::t_sample    i_prev,
    input  psub_pkg::t_sample    i_next,
    output psub_pkg::t_sample    o_data
);
    import psub_pkg::*;

    t_sample r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data <= '0;
        end else if (i_ctl.shift) begin
            r_data <= i_prev;
        end else if (i_ctl.rotate) begin
            r_data <= i_next;
        end
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

FILE: src/psub_intf_cell.sv
// One cell of the interference line; cell 0 holds the current phase.
`default_nettype none

module psub_intf_cell (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_shift,
    input  psub_pkg::t_intf   i_next,
    output psub_pkg::t_intf   o_data
);
    import psub_pkg::*;

    t_intf r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data <= '0;
        end else if (i_shift) begin
            r_data <= i_next;
        end
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

FILE: src/psub_div.sv
// Divide by the cycle length: reciprocal multiply for the quotient, back-multiply for the remainder.
`default_nettype none

module psub_div (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_start,
    input  wire [psub_pkg::U_W-1:0]      i_dividend,
    output logic                         o_done,
    output logic [psub_pkg::U_W-1:0]     o_quot,
    output logic [psub_pkg::DREM_W-1:0]  o_rem
);
    import psub_pkg::*;

    logic              r_stage1;
    logic              r_stage2;
    logic              r_done;
    logic [U_W-1:0]    r_num;
    logic [U_W-1:0]    r_quo;
    logic [DREM_W-1:0] r_rem;

    logic [U_W-1:0]    w_quo;
    logic [U_W-1:0]    w_back;

    // floor(u / N) = (u * ceil(2^k / N)) >> k
    assign w_quo  = U_W'((PROD_W'(r_num) * DIV_RECIP) >> DIV_SHIFT);
    assign w_back = r_quo * U_W'(CYCLE_LEN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage1 <= 1'b0;
            r_stage2 <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_stage1 <= i_start;
            r_stage2 <= r_stage1;
            if (i_start) begin
                r_done <= 1'b0;
            end else if (r_stage2) begin
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
        end
        if (r_stage1) begin
            r_quo <= w_quo;
        end
        if (r_stage2) begin
            r_rem <= DREM_W'(r_num - w_back);
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

FILE: src/powerline_interference_subtractor.sv
// Top level: powerline interference subtractor for ECG samples.
//
//  channel   direction  handshake              payload
//  sample    in         i_valid / o_stall      i_sample     (s16)
//  filtered  out        o_valid / i_stall      o_filtered   (s16)
//  config    in         psel/penable/pwrite    paddr/pwdata (linearity_threshold @ 0x0)
//
//  One sample at a time. A subtract transaction runs evaluate and subtract from accept
//  to the next accept; an averaging transaction runs evaluate, sum, prepare, divide and
//  finish, its length set by the sample line making whole turns past its summing tap and by
//  the two-stage reciprocal divide by CYCLE_LEN.
//  Synchronous active-low reset clears the sample and interference lines, the
//  run counter (to CYCLE_LEN) and the threshold (to 150).
//  o_stall is high while a transaction is in work; a waiting result in the output
//  register holds the block only at its final step, not at accept.
`default_nettype none

module powerline_interference_subtractor (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    // sample in
    input  wire                 i_valid,
    output logic                o_stall,
    input  psub_pkg::t_sample   i_sample,
    // filtered out
    output logic                o_valid,
    input  wire                 i_stall,
    output psub_pkg::t_sample   o_filtered,
    // config
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire [2:0]           paddr,
    input  wire [31:0]          pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import psub_pkg::*;

    // control state
    t_state              r_state, n_state;
    logic [COUNT_W-1:0]  r_count;
    logic [STEP_W-1:0]   r_step;
    logic [15:0]         r_thr;
    logic                r_out_valid;

    // data held across the sequence
    t_sample             r_xd;
    t_sample             r_t;
    logic signed [SUM_W-1:0] r_acc;
    t_sample             r_out_data;

    // line taps
    t_sample             w_ring [RING_LEN];
    t_intf               w_intf [CYCLE_LEN];
    t_intf               w_intf_new;

    // sequencer outputs
    t_ring_ctl           w_ring_ctl;
    logic                w_intf_shift;
    logic                w_div_start;
    logic                w_out_load;

    logic                w_in_accept;
    logic                w_out_free;

    // ---------------------------------------------------------------------
    // config port
    // ---------------------------------------------------------------------
    logic w_cfg_wr;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign pready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= 16'(THRESH_RESET);
        end else if (w_cfg_wr && (paddr[2] == REG_THRESHOLD)) begin
            r_thr <= pwdata[15:0];
        end
    end

    always_comb begin
        if (paddr[2] == REG_THRESHOLD) begin
            prdata = {16'b0, r_thr};
        end else begin
            prdata = '0;
        end
    end

    // ---------------------------------------------------------------------
    // sample line: cell k holds the sample from k transactions ago
    // ---------------------------------------------------------------------
    for (genvar j = 0; j < RING_LEN; j++) begin : g_ring
        t_sample w_prev;
        if (j == 0) begin : g_head
            assign w_prev = i_sample;
        end else begin : g_body
            assign w_prev = w_ring[j-1];
        end
        psub_ring_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ring_ctl),
            .i_prev  (w_prev),
            .i_next  (w_ring[(j + 1) % RING_LEN]),
            .o_data  (w_ring[j])
        );
    end

    // ---------------------------------------------------------------------
    // interference line: turns one place per transaction, cell 0 = phase
    // ---------------------------------------------------------------------
    for (genvar j = 0; j < CYCLE_LEN; j++) begin : g_intf
        t_intf w_next;
        if (j == CYCLE_LEN - 1) begin : g_tail
            assign w_next = w_intf_new;
        end else begin : g_body
            assign w_next = w_intf[j+1];
        end
        psub_intf_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_intf_shift),
            .i_next  (w_next),
            .o_data  (w_intf[j])
        );
    end

    // ---------------------------------------------------------------------
    // linearity test and half difference, on the aligned line
    // ---------------------------------------------------------------------
    logic signed [16:0] w_d1, w_d2, w_dx, w_dx_adj;
    logic signed [17:0] w_crit;
    logic        [17:0] w_crit_abs;
    logic               w_lin;
    logic               w_avg;
    t_sample            w_t;

    assign w_d1   = {w_ring[TAP_CYCLE][15], w_ring[TAP_CYCLE]} - {w_ring[0][15], w_ring[0]};
    assign w_d2   = {w_ring[TAP_CYCLE1][15], w_ring[TAP_CYCLE1]}
                  - {w_ring[1][15], w_ring[1]};
    assign w_crit = {w_d1[16], w_d1} - {w_d2[16], w_d2};
    assign w_crit_abs = w_crit[17] ? 18'(-w_crit) : 18'(w_crit);
    assign w_lin  = w_crit_abs < {2'b0, r_thr};
    assign w_avg  = w_lin && (r_count == COUNT_W'(1));

    // (x - x[n-N]) / 2 truncated toward zero
    assign w_dx     = {w_ring[0][15], w_ring[0]} - {w_ring[TAP_CYCLE][15], w_ring[TAP_CYCLE]};
    assign w_dx_adj = w_dx + {16'b0, w_dx[16]};
    assign w_t      = w_dx_adj[16:1];

    // ---------------------------------------------------------------------
    // divider: s + bias by CYCLE_LEN gives floor quotient and remainder
    // ---------------------------------------------------------------------
    logic signed [SUM_W-1:0] w_s;
    logic [U_W-1:0]          w_dividend;
    logic                    w_div_done;
    logic [U_W-1:0]          w_quot;
    logic [DREM_W-1:0]       w_rem;

    assign w_s        = r_acc - {{(SUM_W - 16){r_t[15]}}, r_t};
    assign w_dividend = {{(U_W - SUM_W){w_s[SUM_W-1]}}, w_s} + DIV_BIAS;

    psub_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    // ---------------------------------------------------------------------
    // average step results
    // ---------------------------------------------------------------------
    logic signed [SUM_W-1:0] w_qs;
    logic                    w_rnd;
    logic signed [SUM_W:0]   w_avg_res;
    logic signed [SUM_W:0]   w_qm;
    logic [DREM_W-1:0]       w_rm;
    logic signed [Q_W-1:0]   w_q;
    t_intf                   w_q_sat;
    t_sample                 w_avg_sat;

    // quotient minus 2^(SUM_W-1): flip the top bit of the low SUM_W bits
    assign w_qs  = {~w_quot[SUM_W-1], w_quot[SUM_W-2:0]};
    assign w_rnd = {w_rem, 1'b0} >= (DREM_W + 1)'(CYCLE_LEN);
    assign w_avg_res = {w_qs[SUM_W-1], w_qs} + {{SUM_W{1'b0}}, w_rnd};

    // (xd*N - s) split as quotient/remainder by N
    assign w_qm = {{(SUM_W - 15){r_xd[15]}}, r_xd} - {w_qs[SUM_W-1], w_qs}
                - {{SUM_W{1'b0}}, (w_rem != '0)};
    assign w_rm = (w_rem == '0) ? '0 : DREM_W'(CYCLE_LEN) - w_rem;
    assign w_q  = {w_qm, FRAC_TAB[w_rm]};

    always_comb begin
        if ((&w_q[Q_W-1:31]) || !(|w_q[Q_W-1:31])) begin
            w_q_sat = w_q[31:0];
        end else begin
            w_q_sat = w_q[Q_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
    end

    always_comb begin
        if ((&w_avg_res[SUM_W:15]) || !(|w_avg_res[SUM_W:15])) begin
            w_avg_sat = w_avg_res[15:0];
        end else begin
            w_avg_sat = w_avg_res[SUM_W] ? 16'h8000 : 16'h7FFF;
        end
    end

    // ---------------------------------------------------------------------
    // subtract step: round(xd - interference), half up
    // ---------------------------------------------------------------------
    logic signed [33:0] w_subv;
    logic signed [17:0] w_subr;
    t_sample            w_sub_sat;

    assign w_subv = {{2{r_xd[15]}}, r_xd, 16'b0} - {{2{w_intf[0][31]}}, w_intf[0]}
                  + 34'sd32768;
    assign w_subr = w_subv[33:16];

    always_comb begin
        if ((&w_subr[17:15]) || !(|w_subr[17:15])) begin
            w_sub_sat = w_subr[15:0];
        end else begin
            w_sub_sat = w_subr[17] ? 16'h8000 : 16'h7FFF;
        end
    end

    assign w_intf_new = (r_state == ST_FIN) ? w_q_sat : w_intf[0];

    // ---------------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------------
    assign w_out_free  = !r_out_valid || !i_stall;
    assign o_stall     = (r_state != ST_IDLE);
    assign w_in_accept = i_valid && !o_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_in_accept) n_state = ST_EVAL;
            ST_EVAL: n_state = w_avg ? ST_SUM : ST_SUB;
            ST_SUB:  if (w_out_free) n_state = ST_IDLE;
            ST_SUM:  if (r_step == STEP_W'(SUM_LEN)) n_state = ST_PREP;
            ST_PREP: n_state = ST_DIV;
            ST_DIV:  if (w_div_done) n_state = ST_FIN;
            ST_FIN:  if (w_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_ring_ctl.shift  = w_in_accept;
        w_ring_ctl.rotate = 1'b0;
        w_intf_shift      = 1'b0;
        w_div_start       = 1'b0;
        w_out_load        = 1'b0;
        unique case (r_state)
            ST_SUM:  w_ring_ctl.rotate = 1'b1;
            ST_PREP: w_div_start = 1'b1;
            ST_SUB, ST_FIN: begin
                w_intf_shift = w_out_free;
                w_out_load   = w_out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= COUNT_W'(CYCLE_LEN);
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_EVAL) begin
                r_step <= STEP_W'(1);
                // average step keeps the count at one
                if (!w_lin) begin
                    r_count <= COUNT_W'(CYCLE_LEN);
                end else if (!w_avg) begin
                    r_count <= r_count - 1'b1;
                end
            end else if (r_state == ST_SUM) begin
                r_step <= r_step + 1'b1;
            end
        end
    end

    // accumulate the last period as the line turns past cell 1
    always_ff @(posedge i_clk) begin
        if (r_state == ST_EVAL) begin
            r_xd  <= w_ring[TAP_DELAY];
            r_t   <= w_t;
            r_acc <= '0;
        end else if ((r_state == ST_SUM) && (r_step <= STEP_W'(CYCLE_LEN))) begin
            r_acc <= r_acc + {{(SUM_W - 16){w_ring[1][15]}}, w_ring[1]};
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_data <= (r_state == ST_FIN) ? w_avg_sat : w_sub_sat;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_filtered = r_out_data;

endmodule

`default_nettype wire
